/* rtl/core/ps2sc_pkg.sv */
// Package for the set-1 scan code decoder: keyboard state type, scan and key
// codes, and the US layout tables. No dependencies.
`timescale 1ns / 1ps

package ps2sc_pkg;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
    logic prefix;
  } kbd_state_t;

  localparam int unsigned TableSize = 96;

  localparam logic [7:0] SC_PREFIX     = 8'hE0;
  localparam logic [7:0] SC_UP         = 8'h48;
  localparam logic [7:0] SC_DOWN       = 8'h50;
  localparam logic [7:0] SC_LEFT       = 8'h4B;
  localparam logic [7:0] SC_RIGHT      = 8'h4D;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] SC_CTRL       = 8'h1D;
  localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
  localparam logic [7:0] SC_ALT        = 8'h38;
  localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_ENTER      = 8'h1C;
  localparam logic [7:0] SC_BKSP       = 8'h0E;
  localparam logic [7:0] SC_TAB        = 8'h0F;
  localparam logic [7:0] SC_SPACE      = 8'h39;
  localparam logic [7:0] SC_ESC        = 8'h01;

  localparam logic [6:0] KEY_NONE     = 7'h00;
  localparam logic [6:0] KEY_ARROW_UP = 7'h1E;
  localparam logic [6:0] KEY_ARROW_DN = 7'h1F;
  localparam logic [6:0] KEY_ARROW_LT = 7'h1A;
  localparam logic [6:0] KEY_ARROW_RT = 7'h1B;
  localparam logic [6:0] KEY_LF       = 7'h0A;
  localparam logic [6:0] KEY_BS       = 7'h08;
  localparam logic [6:0] KEY_TAB      = 7'h09;
  localparam logic [6:0] KEY_SPACE    = 7'h20;
  localparam logic [6:0] KEY_ESC      = 7'h1B;

  localparam logic [6:0] CHR_LOWER_A = 7'h61;
  localparam logic [6:0] CHR_LOWER_Z = 7'h7A;
  localparam logic [6:0] CHR_UPPER_A = 7'h41;
  localparam logic [6:0] CHR_UPPER_Z = 7'h5A;
  localparam logic [6:0] CASE_OFFSET = 7'h20;

  localparam logic [6:0] PLAIN_MAP [TableSize] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] SHIFT_MAP [TableSize] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

/* rtl/core/ps2sc_decode.sv */
// Combinational decode of one set-1 scan byte against the current keyboard
// state, giving the key code and the next state. Depends on ps2sc_pkg.
`timescale 1ns / 1ps

module ps2sc_decode (
  input  logic [7:0]           scan_byte,
  input  ps2sc_pkg::kbd_state_t st_cur,
  output ps2sc_pkg::kbd_state_t st_nxt,
  output logic [6:0]           key_code
);
  import ps2sc_pkg::*;

  logic       in_table;
  logic [6:0] tbl_idx;
  logic [6:0] raw_chr;
  logic [6:0] tbl_chr;

  assign in_table = !scan_byte[7] && (scan_byte[6:5] != 2'b11);
  assign tbl_idx  = in_table ? scan_byte[6:0] : 7'd0;
  assign raw_chr  = st_cur.shift ? SHIFT_MAP[tbl_idx] : PLAIN_MAP[tbl_idx];

  always_comb begin
    tbl_chr = raw_chr;
    if (st_cur.caps) begin
      if (raw_chr >= CHR_LOWER_A && raw_chr <= CHR_LOWER_Z) begin
        tbl_chr = raw_chr - CASE_OFFSET;
      end else if (raw_chr >= CHR_UPPER_A && raw_chr <= CHR_UPPER_Z && st_cur.shift) begin
        tbl_chr = raw_chr + CASE_OFFSET;
      end
    end
  end

  always_comb begin
    st_nxt   = st_cur;
    key_code = KEY_NONE;
    if (scan_byte == SC_PREFIX) begin
      st_nxt.prefix = 1'b1;
    end else if (st_cur.prefix) begin
      st_nxt.prefix = 1'b0;
      unique case (scan_byte)
        SC_UP:    key_code = KEY_ARROW_UP;
        SC_DOWN:  key_code = KEY_ARROW_DN;
        SC_LEFT:  key_code = KEY_ARROW_LT;
        SC_RIGHT: key_code = KEY_ARROW_RT;
        default:  key_code = KEY_NONE;
      endcase
    end else begin
      unique case (scan_byte)
        SC_LSHIFT, SC_RSHIFT:         st_nxt.shift = 1'b1;
        SC_LSHIFT_BRK, SC_RSHIFT_BRK: st_nxt.shift = 1'b0;
        SC_CTRL:                      st_nxt.ctrl  = 1'b1;
        SC_CTRL_BRK:                  st_nxt.ctrl  = 1'b0;
        SC_ALT:                       st_nxt.alt   = 1'b1;
        SC_ALT_BRK:                   st_nxt.alt   = 1'b0;
        SC_CAPS:                      st_nxt.caps  = !st_cur.caps;
        SC_ENTER:                     key_code     = KEY_LF;
        SC_BKSP:                      key_code     = KEY_BS;
        SC_TAB:                       key_code     = KEY_TAB;
        SC_SPACE:                     key_code     = KEY_SPACE;
        SC_ESC:                       key_code     = KEY_ESC;
        default:                      key_code     = in_table ? tbl_chr : KEY_NONE;
      endcase
    end
  end

endmodule

/* rtl/core/ps2_scancode_to_ascii.sv */
// Top level of the set-1 scan code to ASCII decoder: input register, decode
// stage and result register. Depends on ps2sc_pkg and ps2sc_decode.
`timescale 1ns / 1ps

// One scan byte is taken per clock while in_ready is high and gives exactly
// one result. A byte is held in the input register, decoded by a single
// combinational stage that also updates the shift, ctrl, alt, caps lock and
// extended-prefix flags, and lands in the result register once that register
// is free or being read. The sustained rate is one transaction per cycle,
// limited only by the consumer taking results; the input stays ready while a
// single result waits and stalls only when both registers are full and the
// consumer is not ready.
module ps2_scancode_to_ascii (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_key_code,
  output logic       out_shift_now,
  output logic       out_ctrl_now,
  output logic       out_alt_now
);
  import ps2sc_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic [6:0] key_code_r;
  kbd_state_t st_r;
  kbd_state_t st_nxt;
  logic [6:0] key_code_nxt;
  logic       s1_advance;
  logic       s1_fire;

  assign s1_advance = !out_valid_r || out_ready;
  assign s1_fire    = s1_valid_r && s1_advance;
  assign in_ready   = !s1_valid_r || s1_advance;

  ps2sc_decode u_decode (
    .scan_byte (s1_byte_r),
    .st_cur    (st_r),
    .st_nxt    (st_nxt),
    .key_code  (key_code_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_scan_byte;
    end
    if (s1_fire) begin
      key_code_r <= key_code_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_code  = key_code_r;
  assign out_shift_now = st_r.shift;
  assign out_ctrl_now  = st_r.ctrl;
  assign out_alt_now   = st_r.alt;

`ifndef NO_ASSERTIONS
  a_prefix_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_byte_r == SC_PREFIX) |=> st_r.prefix)
    else $error("prefix flag not set after extended prefix byte");

  a_release_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_byte_r[7]) |=> (out_key_code == KEY_NONE))
    else $error("release byte produced a key code");

  a_prefix_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && st_r.prefix && s1_byte_r != SC_PREFIX) |=> !st_r.prefix)
    else $error("prefix flag not cleared by following byte");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");
`endif

endmodule
